>>> hw/rtl/srr_pkg.sv
// shared types and constants for the selective repeat receiver
package srr_pkg;

   localparam int SEQ_W         = 31;
   localparam int WINDOW_W      = 5;
   localparam int PAYLOAD_BYTES = 20;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = 1;
   localparam int QUEUE_COUNT_W = 2;

   localparam logic [SEQ_W-1:0]    SEQ_MAX      = 31'h7FFF_FFFF;
   localparam logic [SEQ_W-1:0]    BASE_RESET   = 31'd1;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 5'd8;

   localparam logic KIND_ACK     = 1'b0;
   localparam logic KIND_DELIVER = 1'b1;

   // one packet as it arrives on the link
   typedef struct packed {
      logic [SEQ_W-1:0]   seq_num;
      logic signed [31:0] ack_num;
      logic signed [31:0] check_value;
      logic [63:0]        payload_low;
      logic [63:0]        payload_mid;
      logic [31:0]        payload_high;
   } req_type;

   // one result: an ack to send back or a message delivered upward
   typedef struct packed {
      logic               kind;
      logic [SEQ_W-1:0]   ack_number;
      logic signed [31:0] ack_check;
      logic [63:0]        data_low;
      logic [63:0]        data_mid;
      logic [31:0]        data_high;
      logic               last;
   } rsp_type;

   // payload bytes with everything after the first zero byte cleared
   typedef struct packed {
      logic [63:0] data_low;
      logic [63:0] data_mid;
      logic [31:0] data_high;
   } payload_type;

   // one checked packet waiting for the window logic
   typedef struct packed {
      logic [SEQ_W-1:0] seq_num;
      payload_type      payload;
   } entry_type;

   // queue fill status
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

>>> hw/rtl/srr_front.sv
// front end: checksum test and payload trimming of arriving packets
module srr_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  srr_pkg::req_type          req_data,
   input  srr_pkg::queue_status_type queue_status,
   output logic                      push,
   output srr_pkg::entry_type        push_entry
);

   logic [7:0]  pkt_bytes  [srr_pkg::PAYLOAD_BYTES];
   logic [7:0]  trim_bytes [srr_pkg::PAYLOAD_BYTES];
   logic        byte_nz    [srr_pkg::PAYLOAD_BYTES];
   logic [10:0] group_sum  [4];
   logic [12:0] byte_sum;
   logic [31:0] check_sum;
   logic        check_ok;

   // split the payload words into bytes
   always_comb begin
      for (int i = 0; i < 8; i++) begin
         pkt_bytes[i]     = req_data.payload_low[8*i +: 8];
         pkt_bytes[8 + i] = req_data.payload_mid[8*i +: 8];
      end
      for (int i = 0; i < 4; i++) begin
         pkt_bytes[16 + i] = req_data.payload_high[8*i +: 8];
      end
   end

   // byte sum in four groups of five, then seq and ack, wrapping at 32 bits
   always_comb begin
      for (int g = 0; g < 4; g++) begin
         group_sum[g] = 11'd0;
         for (int k = 0; k < 5; k++) begin
            group_sum[g] = group_sum[g] + {3'd0, pkt_bytes[5*g + k]};
         end
      end
      byte_sum = {2'd0, group_sum[0]} + {2'd0, group_sum[1]}
               + {2'd0, group_sum[2]} + {2'd0, group_sum[3]};
      check_sum = {19'd0, byte_sum} + {1'b0, req_data.seq_num}
                + $unsigned(req_data.ack_num);
      check_ok = (check_sum == $unsigned(req_data.check_value));
   end

   // clear every byte that follows the first zero byte
   always_comb begin
      logic keep;
      for (int i = 0; i < srr_pkg::PAYLOAD_BYTES; i++) begin
         byte_nz[i] = (pkt_bytes[i] != 8'd0);
      end
      for (int i = 0; i < srr_pkg::PAYLOAD_BYTES; i++) begin
         keep = 1'b1;
         for (int j = 0; j < i; j++) begin
            keep = keep & byte_nz[j];
         end
         trim_bytes[i] = keep ? pkt_bytes[i] : 8'd0;
      end
   end

   // repack into the queue entry
   always_comb begin
      push_entry.seq_num = req_data.seq_num;
      for (int i = 0; i < 8; i++) begin
         push_entry.payload.data_low[8*i +: 8] = trim_bytes[i];
         push_entry.payload.data_mid[8*i +: 8] = trim_bytes[8 + i];
      end
      for (int i = 0; i < 4; i++) begin
         push_entry.payload.data_high[8*i +: 8] = trim_bytes[16 + i];
      end
   end

   // packets that fail the checksum are taken and dropped here
   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full && check_ok;

endmodule

>>> hw/rtl/srr_queue.sv
// short queue of checked packets between front end and window logic
module srr_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  srr_pkg::entry_type        push_entry,
   input  logic                      pop,
   output srr_pkg::entry_type        head_entry,
   output srr_pkg::queue_status_type queue_status
);

   srr_pkg::entry_type                   entries_ff [srr_pkg::QUEUE_DEPTH];
   logic [srr_pkg::QUEUE_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [srr_pkg::QUEUE_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [srr_pkg::QUEUE_COUNT_W-1:0]    count_ff, count_in;
   logic                                 do_push, do_pop;

   localparam logic [srr_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
      srr_pkg::QUEUE_PTR_W'(srr_pkg::QUEUE_DEPTH - 1);
   localparam logic [srr_pkg::QUEUE_COUNT_W-1:0] COUNT_FULL =
      srr_pkg::QUEUE_COUNT_W'(srr_pkg::QUEUE_DEPTH);

   assign queue_status.full  = (count_ff == COUNT_FULL);
   assign queue_status.empty = (count_ff == '0);
   assign head_entry         = entries_ff[rd_ptr_ff];

   assign do_push = push && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   // fill level never passes the depth
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_FULL)
      else $error("queue count above depth");
`endif

endmodule

>>> hw/rtl/srr_back.sv
// window logic: classify, ack, buffer and deliver in order
module srr_back #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [srr_pkg::WINDOW_W-1:0]   window_size,
   input  srr_pkg::queue_status_type      queue_status,
   input  srr_pkg::entry_type             head_entry,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output srr_pkg::rsp_type               rsp_data
);

   localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(MAX_WINDOW - 1);
   localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(1 % MAX_WINDOW);
   localparam logic [SLOT_W:0]   SLOT_WRAP  = (SLOT_W + 1)'(MAX_WINDOW);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DLV_RD,
      S_DLV_OUT
   } state_type;

   state_type                    state_ff, state_in;
   logic [srr_pkg::SEQ_W-1:0]    base_ff, base_in;
   logic [SLOT_W-1:0]            base_slot_ff, base_slot_in;
   logic [MAX_WINDOW-1:0]        slot_valid_ff, slot_valid_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   srr_pkg::rsp_type             rsp_data_ff, rsp_data_in;

   srr_pkg::payload_type         slot_mem [MAX_WINDOW];
   srr_pkg::payload_type         mem_rd_ff;

   logic [31:0]                  win_ext, win_len, diff, neg_diff;
   logic [SLOT_W:0]              slot_sum, slot_sub;
   logic [SLOT_W-1:0]            slot;
   logic                         in_win, old_win, out_free, classify;
   logic                         buffer_wr, start_dlv, dlv_last;
   logic [srr_pkg::SEQ_W-1:0]    base_next;
   logic [SLOT_W-1:0]            base_slot_next;

   // window bounds and slot of the packet at the head of the queue
   always_comb begin
      win_ext  = {27'd0, window_size};
      win_len  = (win_ext > 32'(MAX_WINDOW)) ? 32'(MAX_WINDOW) : win_ext;
      diff     = {1'b0, head_entry.seq_num} - {1'b0, base_ff};
      neg_diff = {1'b0, base_ff} - {1'b0, head_entry.seq_num};
      in_win   = !diff[31] && (diff < win_len);
      old_win  = diff[31] && (neg_diff <= win_len);
      slot_sum = {1'b0, base_slot_ff} + {1'b0, diff[SLOT_W-1:0]};
      slot_sub = slot_sum - SLOT_WRAP;
      slot     = (slot_sum >= SLOT_WRAP) ? slot_sub[SLOT_W-1:0] : slot_sum[SLOT_W-1:0];
   end

   // base advance; slot index follows, wrapping after the last slot and restarting when the base wraps
   always_comb begin
      base_next = (base_ff == srr_pkg::SEQ_MAX) ? '0 : base_ff + 1'b1;
      if (base_ff == srr_pkg::SEQ_MAX || base_slot_ff == SLOT_LAST) begin
         base_slot_next = '0;
      end else begin
         base_slot_next = base_slot_ff + 1'b1;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign classify  = (state_ff == S_IDLE) && !queue_status.empty && out_free;
   assign pop       = classify;
   assign buffer_wr = classify && in_win && !slot_valid_ff[slot];
   assign start_dlv = classify && in_win && (diff == 32'd0);
   assign dlv_last  = !slot_valid_ff[base_slot_ff];

   // sequencer next state
   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      base_slot_in  = base_slot_ff;
      slot_valid_in = slot_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (classify && (in_win || old_win)) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.kind       = srr_pkg::KIND_ACK;
               rsp_data_in.ack_number = head_entry.seq_num;
               rsp_data_in.ack_check  = $signed({1'b0, head_entry.seq_num});
               rsp_data_in.data_low   = '0;
               rsp_data_in.data_mid   = '0;
               rsp_data_in.data_high  = '0;
               rsp_data_in.last       = !start_dlv;
            end
            if (buffer_wr) begin
               slot_valid_in[slot] = 1'b1;
            end
            if (start_dlv) begin
               state_in = S_DLV_RD;
            end
         end
         S_DLV_RD: begin
            slot_valid_in[base_slot_ff] = 1'b0;
            base_in                     = base_next;
            base_slot_in                = base_slot_next;
            state_in                    = S_DLV_OUT;
         end
         S_DLV_OUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.kind       = srr_pkg::KIND_DELIVER;
               rsp_data_in.ack_number = '0;
               rsp_data_in.ack_check  = '0;
               rsp_data_in.data_low   = mem_rd_ff.data_low;
               rsp_data_in.data_mid   = mem_rd_ff.data_mid;
               rsp_data_in.data_high  = mem_rd_ff.data_high;
               rsp_data_in.last       = dlv_last;
               state_in               = dlv_last ? S_IDLE : S_DLV_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, window and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         base_ff       <= srr_pkg::BASE_RESET;
         base_slot_ff  <= SLOT_RESET;
         slot_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         base_ff       <= base_in;
         base_slot_ff  <= base_slot_in;
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_data_ff   <= rsp_data_in;
      end
   end

   // buffered payloads, one write and one registered read port
   always_ff @(posedge clock) begin
      if (buffer_wr) begin
         slot_mem[slot] <= head_entry.payload;
      end
      if (state_ff == S_DLV_RD) begin
         mem_rd_ff <= slot_mem[base_slot_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // between packets the slot at the base is never holding a message
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !slot_valid_ff[base_slot_ff])
      else $error("buffered message left at receive base");

   // each delivery read finds a buffered message
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DLV_RD |-> slot_valid_ff[base_slot_ff])
      else $error("delivery read from empty slot");

   // each delivery read moves the base on
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DLV_RD |=> base_ff != $past(base_ff))
      else $error("receive base did not advance on delivery");
`endif

endmodule

>>> hw/rtl/selective_repeat_receiver_core.sv
// top level of the selective repeat receiver
// Receiver side of selective repeat ARQ. A packet is taken whenever the
// two-entry queue behind the checksum front end has room; packets that
// fail the checksum are taken and dropped there. The window sequencer
// then takes each queued packet to classify it, buffer it and issue its
// ack, and delivers each message released in order through a payload
// memory read and then a result load; it takes no further packet until
// that run of deliveries is through, and it waits while the result side
// stalls. Results leave through an output register and wait there under
// rsp_stall. The window length is written through
// csr_write_enable/csr_write_data (reset 8, values above MAX_WINDOW act as
// MAX_WINDOW) and must only change while the block is idle. MAX_WINDOW sets
// the number of buffer slots.
module selective_repeat_receiver_core #(
   parameter int MAX_WINDOW = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  srr_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output srr_pkg::rsp_type             rsp_data,
   input  logic                         csr_write_enable,
   input  logic [srr_pkg::WINDOW_W-1:0] csr_write_data
);

   logic [srr_pkg::WINDOW_W-1:0] window_ff;
   logic                         push, pop;
   srr_pkg::entry_type           push_entry, head_entry;
   srr_pkg::queue_status_type    queue_status;

   // window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= srr_pkg::WINDOW_RESET;
      end else if (csr_write_enable) begin
         window_ff <= csr_write_data;
      end
   end

   srr_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .queue_status (queue_status),
      .push         (push),
      .push_entry   (push_entry)
   );

   srr_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_entry   (push_entry),
      .pop          (pop),
      .head_entry   (head_entry),
      .queue_status (queue_status)
   );

   srr_back #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .window_size  (window_ff),
      .queue_status (queue_status),
      .head_entry   (head_entry),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

>>> verif/srr_check_pkg.sv
// scoreboard for the selective repeat receiver: window prediction and result checking
`timescale 1ns / 1ps
package srr_check_pkg;

   localparam int MAX_SLOTS      = 16;
   localparam int REPORT_LIMIT   = 10;

   // wrapping sum of the payload bytes, sequence number and ack number
   function automatic logic [31:0] packet_sum(srr_pkg::req_type p);
      logic [159:0] bytes;
      logic [31:0]  sum;
      bytes = {p.payload_high, p.payload_mid, p.payload_low};
      sum = 32'(p.seq_num) + 32'(p.ack_num);
      for (int i = 0; i < srr_pkg::PAYLOAD_BYTES; i++) begin
         sum = sum + 32'(bytes[8*i +: 8]);
      end
      return sum;
   endfunction

   class srr_scoreboard;
      logic [srr_pkg::WINDOW_W-1:0] window;
      logic [srr_pkg::SEQ_W-1:0]    base;
      bit                           held [MAX_SLOTS];
      logic [159:0]                 held_bytes [MAX_SLOTS];
      srr_pkg::rsp_type             expected [$];
      int                           mismatches;
      int                           packets;
      int                           drops;
      int                           acks;
      int                           deliveries;

      function new();
         window = srr_pkg::WINDOW_RESET;
         base = srr_pkg::BASE_RESET;
         foreach (held[i]) held[i] = 1'b0;
         mismatches = 0;
         packets = 0;
         drops = 0;
         acks = 0;
         deliveries = 0;
      endfunction

      // effective window length, capped at the slot count
      function int span();
         return (window > MAX_SLOTS) ? MAX_SLOTS : int'(window);
      endfunction

      function void set_window(logic [srr_pkg::WINDOW_W-1:0] value);
         window = value;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // append one prediction at the tail
      function void queue_result(srr_pkg::rsp_type r);
         expected.insert(expected.size(), r);
      endfunction

      function srr_pkg::rsp_type ack_for(logic [srr_pkg::SEQ_W-1:0] seq);
         srr_pkg::rsp_type r;
         r = '0;
         r.kind = srr_pkg::KIND_ACK;
         r.ack_number = seq;
         r.ack_check = 32'(seq);
         return r;
      endfunction

      // delivered message: bytes after the first zero byte are cleared
      function srr_pkg::rsp_type delivery_of(logic [159:0] bytes);
         srr_pkg::rsp_type r;
         bit               ended;
         ended = 1'b0;
         for (int i = 0; i < srr_pkg::PAYLOAD_BYTES; i++) begin
            if (ended) bytes[8*i +: 8] = 8'h00;
            else if (bytes[8*i +: 8] == 8'h00) ended = 1'b1;
         end
         r = '0;
         r.kind = srr_pkg::KIND_DELIVER;
         r.data_low = bytes[63:0];
         r.data_mid = bytes[127:64];
         r.data_high = bytes[159:128];
         return r;
      endfunction

      // work out the results of one accepted packet
      function void note_packet(srr_pkg::req_type p);
         longint           n;
         longint           b;
         longint           s;
         int               slot;
         srr_pkg::rsp_type prev;
         packets++;
         if (packet_sum(p) != 32'(p.check_value)) begin
            drops++;
            return;
         end
         n = longint'(span());
         b = longint'(base);
         s = longint'(p.seq_num);
         if (s >= b && s <= b + n - 1) begin
            prev = ack_for(p.seq_num);
            slot = int'(p.seq_num % MAX_SLOTS);
            // a duplicate keeps the first copy
            if (!held[slot]) begin
               held[slot] = 1'b1;
               held_bytes[slot] = {p.payload_high, p.payload_mid, p.payload_low};
            end
            // in-order packet releases the run of buffered messages behind it
            if (p.seq_num == base) begin
               for (int i = 0; i < MAX_SLOTS; i++) begin
                  slot = int'(base % MAX_SLOTS);
                  if (!held[slot]) break;
                  queue_result(prev);
                  prev = delivery_of(held_bytes[slot]);
                  held[slot] = 1'b0;
                  base = base + 1'b1;
               end
            end
         end else if (s >= b - n && s <= b - 1) begin
            prev = ack_for(p.seq_num);
         end else begin
            drops++;
            return;
         end
         prev.last = 1'b1;
         queue_result(prev);
      endfunction

      function void report(string what, srr_pkg::rsp_type e, srr_pkg::rsp_type a);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%s", what);
            $display("  expected kind %0d num %h chk %h data %h_%h_%h last %0d",
                     e.kind, e.ack_number, e.ack_check, e.data_high, e.data_mid,
                     e.data_low, e.last);
            $display("  actual   kind %0d num %h chk %h data %h_%h_%h last %0d",
                     a.kind, a.ack_number, a.ack_check, a.data_high, a.data_mid,
                     a.data_low, a.last);
         end
      endfunction

      // compare one result transfer with the oldest prediction
      function void check_result(srr_pkg::rsp_type a);
         srr_pkg::rsp_type e;
         if (a.kind == srr_pkg::KIND_ACK) acks++;
         else deliveries++;
         if (expected.size() == 0) begin
            report("result arrived with nothing expected", '0, a);
            return;
         end
         e = expected.pop_front();
         if (a.kind !== e.kind || a.ack_number !== e.ack_number ||
             a.ack_check !== e.ack_check || a.data_low !== e.data_low ||
             a.data_mid !== e.data_mid || a.data_high !== e.data_high ||
             a.last !== e.last) begin
            report("result field mismatch", e, a);
         end
      endfunction

      // predictions never matched by a result
      function void check_leftover();
         if (expected.size() != 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0d expected results never arrived", expected.size());
         end
      endfunction
   endclass

endpackage

>>> verif/selective_repeat_receiver_core_test.sv
// testbench top for the selective repeat receiver core
`timescale 1ns / 1ps
module selective_repeat_receiver_core_test;

   localparam int SETTLE_CYCLES  = 100;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 40;

   localparam int IDLE_NONE     = 0;
   localparam int IDLE_SENDER   = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH     = 3;

   localparam int PHASE_WINDOW [PHASES] = '{31, 16, 16, 1, 5, 16, 3, 8};

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   srr_pkg::req_type             req_data;
   logic                         rsp_valid;
   logic                         rsp_stall;
   srr_pkg::rsp_type             rsp_data;
   logic                         csr_write_enable;
   logic [srr_pkg::WINDOW_W-1:0] csr_write_data;

   int                          send_idle_pct;
   int                          stall_pct;
   bit                          hold_pending;
   logic [srr_pkg::SEQ_W-1:0]   burst_seqs [$];
   srr_check_pkg::srr_scoreboard sb;

   selective_repeat_receiver_core #(
      .MAX_WINDOW(srr_check_pkg::MAX_SLOTS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: random stall, or one long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // check every result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic srr_pkg::req_type make_packet(logic [srr_pkg::SEQ_W-1:0] seq,
                                                    logic signed [31:0] ack,
                                                    logic [159:0] bytes, bit good);
      srr_pkg::req_type p;
      p.seq_num = seq;
      p.ack_num = ack;
      p.payload_low = bytes[63:0];
      p.payload_mid = bytes[127:64];
      p.payload_high = bytes[159:128];
      p.check_value = srr_check_pkg::packet_sum(p);
      if (!good) p.check_value = p.check_value ^ (32'h1 << $urandom_range(31));
      return p;
   endfunction

   // random bytes with a zero byte now and then
   function automatic logic [159:0] rand_payload();
      logic [159:0] bytes;
      for (int i = 0; i < srr_pkg::PAYLOAD_BYTES; i++) begin
         bytes[8*i +: 8] = ($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255));
      end
      return bytes;
   endfunction

   // next random packet, mostly around the receive window
   function automatic srr_pkg::req_type next_packet();
      logic [srr_pkg::SEQ_W-1:0] seq;
      logic [srr_pkg::SEQ_W-1:0] tmp;
      logic signed [31:0]        ack;
      int                        n;
      int                        pick;
      int                        j;
      n = sb.span();
      // burst: fill the window out of order, then close the gap at base
      if (burst_seqs.size() == 0 && n >= 2 && $urandom_range(99) < 6) begin
         for (int k = 1; k < n; k++)
            burst_seqs.insert(burst_seqs.size(), sb.base + srr_pkg::SEQ_W'(k));
         for (int k = burst_seqs.size() - 1; k > 0; k--) begin
            j = $urandom_range(k);
            tmp = burst_seqs[k];
            burst_seqs[k] = burst_seqs[j];
            burst_seqs[j] = tmp;
         end
         burst_seqs.insert(burst_seqs.size(), sb.base);
      end
      if (burst_seqs.size() != 0)
         return make_packet(burst_seqs.pop_front(), -32'sd1, rand_payload(), 1'b1);
      pick = $urandom_range(99);
      if (n == 0) seq = sb.base - 1'b1 + srr_pkg::SEQ_W'($urandom_range(3));
      else if (pick < 55) seq = sb.base + srr_pkg::SEQ_W'($urandom_range(n - 1));
      else if (pick < 65) seq = sb.base - srr_pkg::SEQ_W'(1 + $urandom_range(n - 1));
      else if (pick < 72) begin
         if ($urandom_range(1) == 1) seq = sb.base + srr_pkg::SEQ_W'(n + $urandom_range(2));
         else seq = sb.base - srr_pkg::SEQ_W'(n + 1 + $urandom_range(2));
      end
      else if (pick < 82) seq = sb.base;
      else seq = srr_pkg::SEQ_W'($urandom());
      ack = ($urandom_range(99) < 80) ? -32'sd1 : $urandom();
      return make_packet(seq, ack, rand_payload(), $urandom_range(99) < 88);
   endfunction

   // offer one packet and hold it until the transfer
   task automatic send_packet(srr_pkg::req_type p);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
      @(negedge clock);
      while (gap > 0) begin
         req_valid <= 1'b0;
         gap--;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= p;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_packet(p);
   endtask

   // stop sending and wait until every predicted result has come out
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(logic [srr_pkg::WINDOW_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_window(value);
   endtask

   task automatic set_idling(int mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 71;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct = 71;
         end
         default: begin
            send_idle_pct = 29;
            stall_pct = 29;
         end
      endcase
   endtask

   // hand-picked packets at the reset window of 8, base starting at 1
   task automatic run_directed();
      logic [159:0]     text;
      srr_pkg::req_type p;
      text = {20{8'h5A}};
      text[23:16] = 8'h00;
      // in order at base: ack then delivery
      send_packet(make_packet(31'd1, -32'sd1, text, 1'b1));
      // out of order, then a duplicate with other bytes
      send_packet(make_packet(31'd3, -32'sd1, '1, 1'b1));
      send_packet(make_packet(31'd3, -32'sd1, rand_payload(), 1'b1));
      send_packet(make_packet(31'd4, 32'sh7FFF_FFFF, '0, 1'b1));
      // closes the gap and releases three messages
      send_packet(make_packet(31'd2, -32'sd1, rand_payload(), 1'b1));
      // below base, ack only
      send_packet(make_packet(31'd0, 32'sh8000_0000, rand_payload(), 1'b1));
      // bad checksum
      send_packet(make_packet(31'd5, -32'sd1, rand_payload(), 1'b0));
      // top edge of the window, then one past it
      send_packet(make_packet(31'd12, -32'sd1, rand_payload(), 1'b1));
      send_packet(make_packet(31'd13, -32'sd1, rand_payload(), 1'b1));
      // far out of range with a good checksum
      send_packet(make_packet(srr_pkg::SEQ_MAX, 32'sh7FFF_FFFF, '1, 1'b1));
      send_packet(make_packet(31'd5, 32'sh8000_0000, rand_payload(), 1'b1));
      send_packet(make_packet(31'd4, -32'sd1, text, 1'b1));
      send_packet(make_packet(31'd13, 32'sd0, '1, 1'b1));
      // extreme carried checksums that do not match
      p = make_packet(31'd6, -32'sd1, rand_payload(), 1'b1);
      p.check_value = 32'sh8000_0000;
      send_packet(p);
      p.check_value = 32'sh7FFF_FFFF;
      send_packet(p);
      send_packet(make_packet(31'd6, -32'sd1, '0, 1'b1));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      send_idle_pct = 0;
      stall_pct = 0;
      sb = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      wait_drained();

      // zero window drops everything
      write_window(5'd0);
      repeat (10) send_packet(next_packet());
      wait_drained();

      // random phases over window settings and idling patterns
      for (int ph = 0; ph < PHASES; ph++) begin
         write_window(srr_pkg::WINDOW_W'(PHASE_WINDOW[ph]));
         set_idling(ph % 4);
         burst_seqs.delete();
         if (ph == 2) begin
            @(posedge clock);
            hold_pending = 1'b1;
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (ph == 5 && k == PHASE_ITEMS / 2) wait_drained();
            send_packet(next_packet());
         end
         wait_drained();
      end

      sb.check_leftover();
      $display("sent %0d packets (%0d dropped) over windows 0 to 31 under mixed idling",
               sb.packets, sb.drops);
      $display("checked %0d acks and %0d deliveries", sb.acks, sb.deliveries);
      if (sb.mismatches == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule

>>> sim.f
hw/rtl/srr_pkg.sv
hw/rtl/srr_front.sv
hw/rtl/srr_queue.sv
hw/rtl/srr_back.sv
hw/rtl/selective_repeat_receiver_core.sv
verif/srr_check_pkg.sv
verif/selective_repeat_receiver_core_test.sv
